/* src/lpht_pkg.sv */
// Shared types, widths and codes for the linear probing hash table.
// Used by the slot memory, the home slot unit and the top level.
package lpht_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int KEY_BYTES    = 8;

    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int KEY_W        = 8 * KEY_BYTES;
    localparam int KEY_NAME_W   = 64;
    localparam int PHONE_W      = 34;
    localparam int SLOT_FIELD_W = 4;
    localparam int SUM_W        = $clog2(KEY_BYTES * 255 + 1);
    localparam int STEP_W       = $clog2(KEY_BYTES + 1);

    localparam int S_TDATA_W    = ((KEY_NAME_W + PHONE_W + 7) / 8) * 8;
    localparam int M_FIELDS_W   = SLOT_FIELD_W + PHONE_W + 1 + SLOT_FIELD_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic [SLOT_W-1:0]       t_slot;
    typedef logic [SLOT_FIELD_W-1:0] t_slot_field;
    typedef logic [KEY_W-1:0]        t_key;
    typedef logic [PHONE_W-1:0]      t_phone;
    typedef logic [1:0]              t_cmd;
    typedef logic [1:0]              t_status;

    localparam t_cmd CMD_INSERT      = 2'd0;
    localparam t_cmd CMD_INSERT_REPL = 2'd1;
    localparam t_cmd CMD_LOOKUP      = 2'd2;
    localparam t_cmd CMD_NONE        = 2'd3;

    localparam t_status ST_INSERTED  = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_FOUND     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic   valid;
        t_key   key;
        t_phone phone;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_slot  addr;
        t_entry data;
    } t_mem_wr;

    typedef struct packed {
        logic  done;
        t_slot home;
    } t_hash_res;

    function automatic t_slot_field slot_field(input t_slot a);
        logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
        ext = {{SLOT_FIELD_W{1'b0}}, a};
        return ext[SLOT_FIELD_W-1:0];
    endfunction

endpackage

/* src/lpht_slot_mem.sv */
// Slot store: one valid bit, key and phone number per slot.
// One write and one registered read per cycle; depends on lpht_pkg.
module lpht_slot_mem (
    input  logic             i_clk,
    input  lpht_pkg::t_mem_wr i_wr,
    input  logic             i_rd_en,
    input  lpht_pkg::t_slot  i_rd_addr,
    output lpht_pkg::t_entry o_rd_data
);
    import lpht_pkg::*;

    t_entry r_mem [SLOT_COUNT];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/lpht_home_unit.sv */
// Home slot unit: byte sum of a key through one shared adder, one byte
// per cycle, reduced modulo the slot count; depends on lpht_pkg.
module lpht_home_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lpht_pkg::t_key      i_key,
    output lpht_pkg::t_hash_res o_res
);
    import lpht_pkg::*;

    t_key              r_key, n_key;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [STEP_W-1:0] r_left, n_left;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    always_comb begin
        n_key  = r_key;
        n_sum  = r_sum;
        n_left = r_left;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_key  = i_key;
            n_sum  = '0;
            n_left = STEP_W'(KEY_BYTES);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_sum  = r_sum + SUM_W'(r_key[7:0]);
            n_key  = r_key >> 8;
            n_left = r_left - 1'b1;
            if (r_left == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_key  <= n_key;
        r_sum  <= n_sum;
        r_left <= n_left;
    end

    assign o_res.done = r_done;
    assign o_res.home = SLOT_W'(r_sum % SLOT_COUNT);

endmodule

/* src/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: command sequencer, result
// register and slot clearing; uses lpht_pkg, lpht_home_unit, lpht_slot_mem.
//
//  channel | direction | tdata (low bit up)                    | tuser
//  s_axis  | in        | key_name[63:0], phone_in[33:0], pad   | cmd[1:0]
//  m_axis  | out       | slot, phone_out, moved, moved_to, pad | status[1:0]
//
// A command runs through the home slot unit, one key byte per cycle, then each
// probed slot is read and then checked, and the result is loaded last. Insert
// with replacement that finds home taken and a free slot recomputes the home
// of the resident entry; relocating that entry adds a write of the new entry
// to the home slot.
// After reset a clearing pass over every slot holds s_axis_tready low.
// A waiting result does not block the next transaction from being accepted;
// the next result holds in the sequencer until the output register frees.
module linear_probe_hash_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lpht_pkg::S_TDATA_W-1:0] s_axis_tdata,  // key_name, phone_in
    input  lpht_pkg::t_cmd                s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lpht_pkg::M_TDATA_W-1:0] m_axis_tdata,  // slot, phone_out, moved, moved_to
    output lpht_pkg::t_status             m_axis_tuser   // status
);
    import lpht_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_HASH2 = 3'd5;
    localparam logic [2:0] S_MOVE  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state, n_state;
    t_cmd       r_cmd, n_cmd;
    t_key       r_key, n_key;
    t_phone     r_phone, n_phone;
    t_slot      r_home, n_home;
    t_slot      r_probe, n_probe;
    t_slot      r_count, n_count;
    t_key       r_disp_key, n_disp_key;
    t_phone     r_disp_phone, n_disp_phone;

    t_status    r_res_status, n_res_status;
    t_slot      r_res_slot, n_res_slot;
    t_phone     r_res_phone, n_res_phone;
    logic       r_res_moved, n_res_moved;
    t_slot      r_res_moved_to, n_res_moved_to;

    logic        r_out_valid, n_out_valid;
    t_status     r_out_status, n_out_status;
    t_slot_field r_out_slot, n_out_slot;
    t_phone      r_out_phone, n_out_phone;
    logic        r_out_moved, n_out_moved;
    t_slot_field r_out_moved_to, n_out_moved_to;

    logic       in_accept;
    t_key       in_key;
    t_phone     in_phone;
    logic       hash_start;
    t_key       hash_key;
    t_hash_res  hash_res;
    t_mem_wr    mem_wr;
    logic       rd_en;
    t_entry     rd_data;
    t_slot      probe_next;
    logic       probe_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_key        = s_axis_tdata[KEY_W-1:0];
    assign in_phone      = s_axis_tdata[KEY_NAME_W +: PHONE_W];

    assign probe_next = (r_probe == t_slot'(SLOT_COUNT - 1)) ? '0 : r_probe + 1'b1;
    assign probe_last = (r_count == t_slot'(SLOT_COUNT - 1));

    lpht_home_unit u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (hash_key),
        .o_res   (hash_res)
    );

    lpht_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_probe),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_key          = r_key;
        n_phone        = r_phone;
        n_home         = r_home;
        n_probe        = r_probe;
        n_count        = r_count;
        n_disp_key     = r_disp_key;
        n_disp_phone   = r_disp_phone;
        n_res_status   = r_res_status;
        n_res_slot     = r_res_slot;
        n_res_phone    = r_res_phone;
        n_res_moved    = r_res_moved;
        n_res_moved_to = r_res_moved_to;
        n_out_valid    = r_out_valid && !m_axis_tready;
        n_out_status   = r_out_status;
        n_out_slot     = r_out_slot;
        n_out_phone    = r_out_phone;
        n_out_moved    = r_out_moved;
        n_out_moved_to = r_out_moved_to;
        hash_start     = 1'b0;
        hash_key       = r_disp_key;
        rd_en          = 1'b0;
        mem_wr.en      = 1'b0;
        mem_wr.addr    = r_probe;
        mem_wr.data    = '{valid: 1'b1, key: r_key, phone: r_phone};

        case (r_state)
            S_CLEAR: begin
                mem_wr.en         = 1'b1;
                mem_wr.data.valid = 1'b0;
                n_probe           = probe_next;
                if (r_probe == t_slot'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                hash_key = in_key;
                if (in_accept && s_axis_tuser != CMD_NONE) begin
                    hash_start     = 1'b1;
                    n_cmd          = s_axis_tuser;
                    n_key          = in_key;
                    n_phone        = in_phone;
                    n_res_status   = ST_INSERTED;
                    n_res_slot     = '0;
                    n_res_phone    = '0;
                    n_res_moved    = 1'b0;
                    n_res_moved_to = '0;
                    n_state        = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_res.done) begin
                    n_home  = hash_res.home;
                    n_probe = hash_res.home;
                    n_count = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                case (r_cmd)
                    CMD_LOOKUP: begin
                        if (rd_data.valid && rd_data.key == r_key) begin
                            n_res_status = ST_FOUND;
                            n_res_slot   = r_probe;
                            n_res_phone  = rd_data.phone;
                            n_state      = S_OUT;
                        end else if (probe_last) begin
                            n_res_status = ST_NOT_FOUND;
                            n_state      = S_OUT;
                        end else begin
                            n_probe = probe_next;
                            n_count = r_count + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    CMD_INSERT, CMD_INSERT_REPL: begin
                        if (r_count == '0) begin
                            n_disp_key   = rd_data.key;
                            n_disp_phone = rd_data.phone;
                        end
                        if (!rd_data.valid) begin
                            if (r_cmd == CMD_INSERT_REPL && r_count != '0) begin
                                hash_start = 1'b1;
                                n_state    = S_HASH2;
                            end else begin
                                mem_wr.en  = 1'b1;
                                n_res_slot = r_probe;
                                n_state    = S_OUT;
                            end
                        end else if (probe_last) begin
                            n_res_status = ST_FULL;
                            n_state      = S_OUT;
                        end else begin
                            n_probe = probe_next;
                            n_count = r_count + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_HASH2: begin
                if (hash_res.done) begin
                    mem_wr.en = 1'b1;
                    if (hash_res.home == r_home) begin
                        n_res_slot = r_probe;
                        n_state    = S_OUT;
                    end else begin
                        mem_wr.data = '{valid: 1'b1, key: r_disp_key, phone: r_disp_phone};
                        n_state     = S_MOVE;
                    end
                end
            end
            S_MOVE: begin
                mem_wr.en      = 1'b1;
                mem_wr.addr    = r_home;
                n_res_slot     = r_home;
                n_res_moved    = 1'b1;
                n_res_moved_to = r_probe;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid    = 1'b1;
                    n_out_status   = r_res_status;
                    n_out_slot     = slot_field(r_res_slot);
                    n_out_phone    = r_res_phone;
                    n_out_moved    = r_res_moved;
                    n_out_moved_to = slot_field(r_res_moved_to);
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_probe     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_probe     <= n_probe;
            r_out_valid <= n_out_valid;
        end
        r_cmd          <= n_cmd;
        r_key          <= n_key;
        r_phone        <= n_phone;
        r_home         <= n_home;
        r_count        <= n_count;
        r_disp_key     <= n_disp_key;
        r_disp_phone   <= n_disp_phone;
        r_res_status   <= n_res_status;
        r_res_slot     <= n_res_slot;
        r_res_phone    <= n_res_phone;
        r_res_moved    <= n_res_moved;
        r_res_moved_to <= n_res_moved_to;
        r_out_status   <= n_out_status;
        r_out_slot     <= n_out_slot;
        r_out_phone    <= n_out_phone;
        r_out_moved    <= n_out_moved;
        r_out_moved_to <= n_out_moved_to;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = M_TDATA_W'({r_out_moved_to, r_out_moved, r_out_phone, r_out_slot});

endmodule

/* test/tb_linear_probe_hash_table.sv */
// Self-checking testbench for linear_probe_hash_table: drives commands on s_axis,
// predicts each reply from its own copy of the slots and checks m_axis replies.
// Depends on lpht_pkg and the linear_probe_hash_table top level.
module tb_linear_probe_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    typedef logic [KEY_NAME_W-1:0] t_name;

    typedef struct {
        t_cmd   cmd;
        t_name  name;
        t_phone phone;
    } t_command;

    typedef struct {
        t_status     status;
        t_slot_field slot;
        t_phone      phone;
        logic        moved;
        t_slot_field moved_to;
    } t_reply;

    localparam int PAD_W      = S_TDATA_W - KEY_NAME_W - PHONE_W;
    localparam int MOVED_BIT  = SLOT_FIELD_W + PHONE_W;
    localparam int HOLD_AFTER = 1200;
    localparam int HOLD_LEN   = 500;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // key_name, phone_in, pad
    t_cmd                 s_axis_tuser = CMD_NONE;  // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;  // slot, phone_out, moved, moved_to, pad
    t_status              m_axis_tuser;  // status

    t_command commands_pending[$];
    t_reply   replies_due[$];
    t_name    known_names[$];
    int       planned_inserts = 0;
    int       accepted_count = 0;
    int       error_count = 0;
    int       tx_wait = 0;
    int       rx_wait = 0;
    logic     calm = 1'b0;
    logic     rx_hold = 1'b0;

    logic   book_valid [SLOT_COUNT];
    t_key   book_key   [SLOT_COUNT];
    t_phone book_phone [SLOT_COUNT];

    linear_probe_hash_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL linear_probe_hash_table");
        $finish;
    end

    function automatic int home_slot(t_key k);
        int sum;
        sum = 0;
        for (int b = 0; b < KEY_BYTES; b++) sum += int'(k[8*b +: 8]);
        return sum % SLOT_COUNT;
    endfunction

    function automatic int first_free(int start, int count);
        for (int i = 0; i < count; i++) begin
            if (!book_valid[(start + i) % SLOT_COUNT]) return (start + i) % SLOT_COUNT;
        end
        return -1;
    endfunction

    function automatic void put_entry(int s, t_key k, t_phone p);
        book_valid[s] = 1'b1;
        book_key[s]   = k;
        book_phone[s] = p;
    endfunction

    function automatic bit resolve_command(input t_command c, output t_reply r);
        t_key key;
        int   home;
        int   free_at;
        int   s;
        key        = c.name[KEY_W-1:0];
        home       = home_slot(key);
        r.status   = ST_INSERTED;
        r.slot     = '0;
        r.phone    = '0;
        r.moved    = 1'b0;
        r.moved_to = '0;
        case (c.cmd)
            CMD_NONE: begin
                return 1'b0;
            end
            CMD_INSERT: begin
                free_at = first_free(home, SLOT_COUNT);
                if (free_at < 0) begin
                    r.status = ST_FULL;
                end else begin
                    put_entry(free_at, key, c.phone);
                    r.slot = free_at[SLOT_FIELD_W-1:0];
                end
            end
            CMD_INSERT_REPL: begin
                if (!book_valid[home]) begin
                    put_entry(home, key, c.phone);
                    r.slot = home[SLOT_FIELD_W-1:0];
                end else begin
                    free_at = first_free((home + 1) % SLOT_COUNT, SLOT_COUNT - 1);
                    if (free_at < 0) begin
                        r.status = ST_FULL;
                    end else if (home_slot(book_key[home]) == home) begin
                        put_entry(free_at, key, c.phone);
                        r.slot = free_at[SLOT_FIELD_W-1:0];
                    end else begin
                        put_entry(free_at, book_key[home], book_phone[home]);
                        put_entry(home, key, c.phone);
                        r.slot     = home[SLOT_FIELD_W-1:0];
                        r.moved    = 1'b1;
                        r.moved_to = free_at[SLOT_FIELD_W-1:0];
                    end
                end
            end
            default: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    s = (home + i) % SLOT_COUNT;
                    if (book_valid[s] && book_key[s] == key) begin
                        r.status = ST_FOUND;
                        r.slot   = s[SLOT_FIELD_W-1:0];
                        r.phone  = book_phone[s];
                        break;
                    end
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_phone rand_phone();
        t_phone p;
        int     r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        p[31:0]         = $urandom;
        p[PHONE_W-1:32] = (PHONE_W-32)'($urandom);
        return p;
    endfunction

    function automatic t_name rand_name();
        t_name n;
        int    r;
        int    len;
        r   = $urandom_range(0, 9);
        n   = '0;
        len = $urandom_range(1, KEY_NAME_W / 8);
        if (r < 4) begin
            n[31:0]            = $urandom;
            n[KEY_NAME_W-1:32] = $urandom;
        end else if (r < 9) begin
            for (int b = 0; b < len; b++) begin
                n[8*b +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(97, 122))
                                                   : 8'($urandom_range(65, 90));
            end
        end else begin
            for (int b = 0; b < len; b++) n[8*b +: 8] = 8'($urandom_range(1, 255));
        end
        return n;
    endfunction

    function automatic t_name name_at_home(int h);
        t_name n;
        int    upper;
        n     = rand_name();
        upper = 0;
        for (int b = 1; b < KEY_BYTES; b++) upper += int'(n[8*b +: 8]);
        n[7:0] = 8'(((h - upper) & (SLOT_COUNT - 1)) | ($urandom_range(0, 15) << 4));
        return n;
    endfunction

    function automatic t_name pick_known();
        return known_names[$urandom_range(0, known_names.size() - 1)];
    endfunction

    task automatic push_cmd(t_cmd cmd, t_name name, t_phone phone);
        t_command c;
        c.cmd   = cmd;
        c.name  = name;
        c.phone = phone;
        if (cmd == CMD_INSERT || cmd == CMD_INSERT_REPL) begin
            planned_inserts++;
            known_names.push_back(name);
        end
        commands_pending.push_back(c);
    endtask

    task automatic push_random(int count);
        t_cmd  cmd;
        t_name name;
        int    r;
        int    insert_top;
        for (int i = 0; i < count; i++) begin
            r          = $urandom_range(0, 999);
            insert_top = (planned_inserts < SLOT_COUNT) ? 40 : 130;
            if (r < 30) begin
                cmd  = CMD_NONE;
                name = rand_name();
            end else if (r < insert_top) begin
                cmd = $urandom_range(0, 1) ? CMD_INSERT_REPL : CMD_INSERT;
                r   = $urandom_range(0, 9);
                if (r < 2) name = pick_known();
                else if (r < 6) name = name_at_home((home_slot(pick_known())
                                                     + $urandom_range(0, 1)) % SLOT_COUNT);
                else name = rand_name();
            end else begin
                cmd = CMD_LOOKUP;
                r   = $urandom_range(0, 19);
                if (r < 12) name = pick_known();
                else if (r < 17) name = rand_name();
                else name = name_at_home(home_slot(pick_known()));
            end
            push_cmd(cmd, name, rand_phone());
        end
    endtask

    task automatic drain();
        while (commands_pending.size() != 0 || s_axis_tvalid || replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (tx_wait > 0) begin
                tx_wait       <= tx_wait - 1;
                s_axis_tvalid <= 1'b0;
            end else if (commands_pending.size() != 0) begin
                t_command c;
                c = commands_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{PAD_W{1'b0}}, c.phone, c.name};
                s_axis_tuser  <= c.cmd;
                tx_wait       <= calm ? 0 : pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : accept_side
        t_command c;
        t_reply   r;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            c.cmd   = s_axis_tuser;
            c.name  = s_axis_tdata[KEY_NAME_W-1:0];
            c.phone = s_axis_tdata[KEY_NAME_W +: PHONE_W];
            if (resolve_command(c, r)) replies_due.push_back(r);
            accepted_count++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) rx_wait <= pick_gap();
        end
    end

    always @(posedge i_clk) begin : result_side
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (replies_due.size() == 0) begin
                flag_mismatch("reply with no command", 64'(m_axis_tdata), '0);
            end else begin
                want = replies_due.pop_front();
                if (m_axis_tuser !== want.status)
                    flag_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                if (m_axis_tdata[SLOT_FIELD_W-1:0] !== want.slot)
                    flag_mismatch("slot", 64'(m_axis_tdata[SLOT_FIELD_W-1:0]),
                                  64'(want.slot));
                if (m_axis_tdata[SLOT_FIELD_W +: PHONE_W] !== want.phone)
                    flag_mismatch("phone_out", 64'(m_axis_tdata[SLOT_FIELD_W +: PHONE_W]),
                                  64'(want.phone));
                if (m_axis_tdata[MOVED_BIT] !== want.moved)
                    flag_mismatch("moved", 64'(m_axis_tdata[MOVED_BIT]), 64'(want.moved));
                if (m_axis_tdata[MOVED_BIT+1 +: SLOT_FIELD_W] !== want.moved_to)
                    flag_mismatch("moved_to", 64'(m_axis_tdata[MOVED_BIT+1 +: SLOT_FIELD_W]),
                                  64'(want.moved_to));
            end
        end
    end

    initial begin : long_hold
        wait (accepted_count >= HOLD_AFTER);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_LEN) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin : stimulus
        t_name a_name;
        t_name b_name;
        t_name c_name;
        t_name d_name;
        t_name e_name;
        t_name f_name;
        for (int s = 0; s < SLOT_COUNT; s++) book_valid[s] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        a_name = name_at_home(3);
        b_name = name_at_home(3);
        c_name = name_at_home(4);
        d_name = name_at_home(3);
        e_name = name_at_home(SLOT_COUNT - 1);
        f_name = name_at_home(SLOT_COUNT - 1);
        push_cmd(CMD_LOOKUP, '0, rand_phone());
        push_cmd(CMD_INSERT, '0, '0);
        push_cmd(CMD_LOOKUP, '0, '1);
        push_cmd(CMD_INSERT, '1, '1);
        push_cmd(CMD_LOOKUP, '1, '0);
        push_cmd(CMD_INSERT, a_name, rand_phone());
        push_cmd(CMD_INSERT, b_name, rand_phone());
        push_cmd(CMD_INSERT_REPL, c_name, rand_phone());
        push_cmd(CMD_INSERT_REPL, d_name, rand_phone());
        push_cmd(CMD_LOOKUP, b_name, rand_phone());
        push_cmd(CMD_LOOKUP, c_name, rand_phone());
        push_cmd(CMD_LOOKUP, d_name, rand_phone());
        push_cmd(CMD_INSERT_REPL, e_name, rand_phone());
        push_cmd(CMD_INSERT, f_name, rand_phone());
        push_cmd(CMD_LOOKUP, f_name, rand_phone());
        push_cmd(CMD_INSERT, a_name, rand_phone());
        push_cmd(CMD_LOOKUP, a_name, rand_phone());
        push_cmd(CMD_NONE, rand_name(), rand_phone());
        push_cmd(CMD_LOOKUP, name_at_home(3), rand_phone());
        push_cmd(CMD_NONE, '1, '1);
        push_cmd(CMD_LOOKUP, {8'hff, {(KEY_NAME_W-8){1'b0}}}, rand_phone());
        drain();

        push_random(600);
        drain();

        calm = 1'b1;
        push_random(300);
        drain();
        calm = 1'b0;

        push_random(1000);
        drain();
        repeat (200) @(negedge i_clk);

        if (error_count == 0 && replies_due.size() == 0) begin
            $display("PASS linear_probe_hash_table");
        end else begin
            $display("FAIL linear_probe_hash_table");
        end
        $finish;
    end

endmodule
